>>> hw/rtl/nsdq_pkg.sv
// ----------------------------------------------------------------------------
// nsdq_pkg
// Types, constants and the shaping coefficient table shared by the
// noise-shaped dither quantizer.
// ----------------------------------------------------------------------------
package nsdq_pkg;

   localparam int MAX_CHANNELS  = 8;
   localparam int HISTORY_DEPTH = 21;
   localparam int NUM_ROWS      = 8;
   localparam int HIST_ENTRIES  = MAX_CHANNELS * HISTORY_DEPTH;
   localparam int ADDR_W        = $clog2(HIST_ENTRIES);
   localparam int K_W           = $clog2(HISTORY_DEPTH);
   localparam int ROW_W         = $clog2(NUM_ROWS);

   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 40;
   localparam int NOISE_W  = 23;
   localparam int CODE_W   = 32;
   localparam int HIST_W   = 26;
   localparam int COEF_W   = 28;

   // register indexes
   localparam logic [1:0] REG_DITHER = 2'd0;
   localparam logic [1:0] REG_RATE   = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;

   // output width codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;
   localparam logic [1:0] WIDTH_32 = 2'd3;

   localparam logic [19:0] RATE_48K   = 20'd48000;
   localparam logic [19:0] RATE_44K1  = 20'd44100;
   localparam logic [19:0] RATE_37K8  = 20'd37800;
   localparam logic [19:0] RATE_32K   = 20'd32000;
   localparam logic [19:0] RATE_22K05 = 20'd22050;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   // Q24 coefficient from a value given in units of 1e-8, rounded half away
   // from zero; evaluated at elaboration only
   function automatic coef_type cq(input longint m);
      longint p;
      p = m * longint'(16777216) + ((m < 0) ? -longint'(50000000) : longint'(50000000));
      return COEF_W'(p / 100000000);
   endfunction

   localparam logic [K_W-1:0] TAPS_OF_ROW [NUM_ROWS] = '{
      5'd1, 5'd16, 5'd20, 5'd16, 5'd16, 5'd15, 5'd16, 5'd15
   };

   localparam coef_type SHAPING [NUM_ROWS][HISTORY_DEPTH] = '{
      '{cq(-100000000), 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{cq(-287207294), cq(504132318), cq(-624429941), cq(584839869), cq(-370675421),
        cq(104951191), cq(118302369), cq(-211267924), cq(190945315), cq(-99913085),
        cq(17090806), cq(32615602), cq(-39127645), cq(26876462), cq(-9767611),
        cq(2347385), 0, 0, 0, 0, 0},
      '{cq(-267731977), cq(483089256), cq(-657011032), cq(745720148), cq(-672632742),
        cq(484816504), cq(-204120898), cq(-70063591), cq(295375657), cq(-408003855),
        cq(418452168), cq(-333118129), cq(211799264), cq(-87930298), cq(3175915),
        cq(42382789), cq(-47882104), cq(35490814), cq(-17496839), cq(6090817), 0},
      '{cq(-163359928), cq(226154923), cq(-240770292), cq(263417172), cq(-214403629),
        cq(181532586), cq(-108162248), cq(70302653), cq(-15991993), cq(-4154952),
        cq(29416576), cq(-25183168), cq(27766478), cq(-15785404), cq(10165894),
        cq(-1683389), 0, 0, 0, 0, 0},
      '{cq(-82901299), cq(98922658), cq(-59825712), cq(100288093), cq(-59938216),
        cq(79502451), cq(-42723316), cq(54492527), cq(-30792606), cq(36871800),
        cq(-18792048), cq(22611271), cq(-10573342), cq(11435491), cq(-3880068),
        cq(4084220), 0, 0, 0, 0, 0},
      '{cq(-6522997), cq(54981261), cq(40278548), cq(31783769), cq(28201798),
        cq(16985194), cq(15433364), cq(12507141), cq(8903945), cq(6441012),
        cq(4714600), cq(3280524), cq(2849519), cq(1169501), cq(1183184),
        0, 0, 0, 0, 0, 0},
      '{cq(-239257741), cq(343502975), cq(-318537092), cq(181172717), cq(20124771),
        cq(-147599077), cq(172109044), cq(-97746700), cq(13790138), cq(38185903),
        cq(-27421242), cq(-6658421), cq(35223302), cq(-37672344), cq(23964277),
        cq(-6867483), 0, 0, 0, 0, 0},
      '{cq(-208339167), cq(304184508), cq(-320478988), cq(275719261), cq(-149786305),
        cq(34275946), cq(71733749), cq(-107370579), cq(102258158), cq(-56649995),
        cq(20968692), cq(6537853), cq(-10322438), cq(6744202), cq(495197),
        0, 0, 0, 0, 0, 0}
   };

endpackage

>>> hw/rtl/nsdq_if.sv
// ----------------------------------------------------------------------------
// nsdq_if
// Valid/ready channels of the quantizer: sample request and code response.
// ----------------------------------------------------------------------------
interface nsdq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [nsdq_pkg::CH_W-1:0]            channel;
   logic signed [nsdq_pkg::SAMPLE_W-1:0] sample;
   logic signed [nsdq_pkg::NOISE_W-1:0]  noise;

   modport source (output valid, channel, sample, noise, input ready);
   modport sink   (input valid, channel, sample, noise, output ready);
endinterface

interface nsdq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nsdq_pkg::CODE_W-1:0]   sample_code;

   modport source (output valid, sample_code, input ready);
   modport sink   (input valid, sample_code, output ready);
endinterface

>>> hw/rtl/nsdq_ram.sv
// ----------------------------------------------------------------------------
// nsdq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nsdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hw/rtl/noise_shaped_dither_quantizer_top.sv
// ----------------------------------------------------------------------------
// noise_shaped_dither_quantizer_top
// Scales a sample to the PCM width, adds dither and error feedback from the
// channel's history, rounds half to even and saturates.
//
//   port    dir    kind         word
//   req     in     valid/ready  channel, sample, noise
//   rsp     out    valid/ready  sample_code
//   csr_*   in     APB          dither_setting, sample_rate, output_width_code
//
// With dither on, the tap loop reads one history entry per cycle from the
// history RAM; with dither off the item skips the tap loop.
// Synchronous reset; history entries carry valid bits, so reset and writes of
// the dither setting or the rate clear the history at once.
// A stalled response holds the item in its last step; req is taken in idle.
// ----------------------------------------------------------------------------
module noise_shaped_dither_quantizer_top (
   input  logic        clock,
   input  logic        reset,
   nsdq_req_if.sink    req,
   nsdq_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import nsdq_pkg::*;

   // configuration
   logic [2:0]  dither_ff;
   logic [19:0] rate_ff;
   logic [1:0]  wcode_ff;
   logic        cfg_wr;
   logic [1:0]  cfg_idx;
   logic        hist_clear;

   // control
   state_type state_ff, state_in;
   logic                 accept;
   logic                 out_free;
   logic [2:0]           setting;
   logic [2:0]           sel;
   logic [ROW_W-1:0]     row_pick;
   logic [2:0]           rate_row;
   logic                 active_ff, fb_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [K_W-1:0]       taps_ff;
   logic [K_W-1:0]       k_ff;
   logic [ADDR_W-1:0]    base_ff;

   // datapath
   logic signed [SAMPLE_W-1:0] whole_in, whole_ff;
   logic [23:0]                frac_in, frac_ff;
   logic signed [NOISE_W-1:0]  nz_ff;
   logic                       rd_en, rd_pend_ff, rd_vld_ff, prod_vld_ff;
   logic [K_W-1:0]             kd_ff;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;
   logic                       wr_en;
   logic [HIST_W-1:0]          wr_data, rd_data;
   logic signed [HIST_W-1:0]   hist_val;
   logic signed [53:0]         prod_ff;
   logic signed [59:0]         acc_ff;
   logic signed [35:0]         fb_round;
   logic signed [36:0]         t_ff;
   logic [HIST_ENTRIES-1:0]    valid_ff;
   logic                       shift_wr;
   logic [K_W:0]               kd_next;

   // rounding
   logic signed [12:0] ti;
   logic [23:0]        tf;
   logic signed [40:0] n_val;
   logic               inc;
   logic signed [41:0] rounded, hi, lo, sat;
   logic [CODE_W-1:0]  code;
   logic [HIST_W-1:0]  err;
   logic               rsp_valid_ff;
   logic [CODE_W-1:0]  rsp_code_ff;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx    = csr_paddr[3:2];
   assign hist_clear = cfg_wr && (cfg_idx == REG_DITHER || cfg_idx == REG_RATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 3'd0;
         rate_ff   <= RATE_44K1;
         wcode_ff  <= WIDTH_16;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_DITHER: dither_ff <= csr_pwdata[2:0];
            REG_RATE:   rate_ff   <= csr_pwdata[19:0];
            REG_WIDTH:  wcode_ff  <= csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_DITHER: csr_prdata = {29'd0, dither_ff};
         REG_RATE:   csr_prdata = {12'd0, rate_ff};
         REG_WIDTH:  csr_prdata = {30'd0, wcode_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- row selection ----------------
   assign setting = (dither_ff > 3'd4) ? 3'd4 : dither_ff;
   assign sel     = setting - 3'd1;

   always_comb begin
      priority if (rate_ff == RATE_48K)   rate_row = 3'd1;
      else if     (rate_ff == RATE_44K1)  rate_row = 3'd2;
      else if     (rate_ff == RATE_37K8)  rate_row = 3'd3;
      else if     (rate_ff == RATE_32K)   rate_row = 3'd4;
      else if     (rate_ff == RATE_22K05) rate_row = 3'd5;
      else                                rate_row = 3'd6;
   end

   always_comb begin
      priority if (sel == 3'd1 || rate_row == 3'd6) row_pick = '0;
      else if (sel == 3'd3 && (rate_row == 3'd1 || rate_row == 3'd2))
         row_pick = ROW_W'(rate_row + 3'd5);
      else row_pick = ROW_W'(rate_row);
   end

   // ---------------- scaling to output LSBs ----------------
   always_comb begin
      unique case (wcode_ff)
         WIDTH_8: begin
            whole_in = req.sample >>> 24;
            frac_in  = req.sample[23:0];
         end
         WIDTH_16: begin
            whole_in = req.sample >>> 16;
            frac_in  = {req.sample[15:0], 8'd0};
         end
         WIDTH_24: begin
            whole_in = req.sample >>> 8;
            frac_in  = {req.sample[7:0], 16'd0};
         end
         default: begin
            whole_in = req.sample;
            frac_in  = 24'd0;
         end
      endcase
   end

   // ---------------- control ----------------
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = (setting != 3'd0) ? ST_READ : ST_SUM;
         ST_READ:  if (k_ff == '0) state_in = ST_DRAIN;
         ST_DRAIN: if (!rd_pend_ff && !prod_vld_ff) state_in = ST_SUM;
         ST_SUM:   state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // reads walk the taps from the oldest entry down, so each shift write
   // lands on an entry that has already been read
   always_comb begin
      rd_en   = (state_ff == ST_READ);
      rd_addr = base_ff + ADDR_W'(k_ff);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         active_ff <= (setting != 3'd0);
         fb_ff     <= (setting >= 3'd2);
         row_ff    <= row_pick;
         taps_ff   <= TAPS_OF_ROW[row_pick];
         k_ff      <= TAPS_OF_ROW[row_pick] - K_W'(1);
         base_ff   <= ADDR_W'(req.channel) * ADDR_W'(HISTORY_DEPTH);
         whole_ff  <= whole_in;
         frac_ff   <= frac_in;
         nz_ff     <= (setting != 3'd0) ? req.noise : '0;
      end else if (rd_en && k_ff != '0) begin
         k_ff <= k_ff - K_W'(1);
      end
   end

   // ---------------- history RAM and MAC ----------------
   nsdq_ram #(.WIDTH(HIST_W), .DEPTH(HIST_ENTRIES)) u_hist (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hist_val = rd_vld_ff ? $signed(rd_data) : '0;
   assign kd_next  = {1'b0, kd_ff} + 1'b1;
   assign shift_wr = rd_pend_ff && (kd_next < {1'b0, taps_ff});

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = base_ff + ADDR_W'(kd_next);
      wr_data = hist_val;
      if (shift_wr) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_DONE && out_free && active_ff) begin
         wr_en   = 1'b1;
         wr_addr = base_ff;
         wr_data = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         rd_pend_ff  <= rd_en;
         prod_vld_ff <= rd_pend_ff;
         if (hist_clear) valid_ff <= '0;
         else if (wr_en) valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kd_ff     <= k_ff;
      rd_vld_ff <= valid_ff[rd_addr];
      prod_ff   <= SHAPING[row_ff][kd_ff] * hist_val;
      if (accept) acc_ff <= '0;
      else if (prod_vld_ff && fb_ff) acc_ff <= acc_ff + 60'(prod_ff);
   end

   // feedback rounded back to 24 fraction bits
   assign fb_round = 36'((acc_ff + 60'sd8388608) >>> 24);

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         t_ff <= $signed({13'd0, frac_ff}) + 37'(nz_ff) + (fb_ff ? 37'(fb_round) : 37'sd0);
      end
   end

   // ---------------- round half to even, saturate ----------------
   assign ti      = t_ff[36:24];
   assign tf      = t_ff[23:0];
   assign n_val   = 41'(whole_ff) + 41'(ti);
   assign inc     = (tf > 24'h800000) || (tf == 24'h800000 && n_val[0]);
   assign rounded = 42'(n_val) + (inc ? 42'sd1 : 42'sd0);
   assign err     = {2'b00, tf} - (inc ? 26'h1000000 : 26'h0);

   always_comb begin
      unique case (wcode_ff)
         WIDTH_8:  hi = 42'sd127;
         WIDTH_16: hi = 42'sd32767;
         WIDTH_24: hi = 42'sd8388607;
         default:  hi = 42'sd2147483647;
      endcase
      lo = -hi - 42'sd1;
      priority if (rounded > hi) sat = hi;
      else if (rounded < lo)     sat = lo;
      else                       sat = rounded;
      unique case (wcode_ff)
         WIDTH_8:  code = {24'd0, sat[7] ^ 1'b1, sat[6:0]};
         WIDTH_16: code = {16'd0, sat[15:0]};
         WIDTH_24: code = {8'd0, sat[23:0]};
         default:  code = sat[31:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) rsp_code_ff <= code;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sample_code = rsp_code_ff;

   // ---------------- assertions ----------------
   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("history read and write hit the same entry");

   a_tap_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (k_ff < taps_ff))
      else $error("tap index beyond row length");

   a_wr_in_channel: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr >= base_ff && wr_addr < base_ff + ADDR_W'(HISTORY_DEPTH)))
      else $error("history write outside channel block");

   a_pipe_in_loop: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_READ || state_ff == ST_DRAIN))
      else $error("read in flight outside tap loop");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the noise-shaped dither quantizer against an in-bench model of the
// scaling, dither, error-feedback, half-to-even rounding and saturation.
// Runs phases of settings written over APB while idle, with directed words
// first, then random words with random gaps on all eight channels.
// ----------------------------------------------------------------------------
module testbench;
   import nsdq_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0]            ch;
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [NOISE_W-1:0]  nz;
   } pcm_word_type;

   localparam int NPHASE = 14;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nsdq_req_if req_if ();
   nsdq_rsp_if rsp_if ();

   noise_shaped_dither_quantizer_top dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shaping taps in units of 1e-8
   localparam longint TAP_E8 [NUM_ROWS][HISTORY_DEPTH] = '{
      '{-100000000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{-287207294, 504132318, -624429941, 584839869, -370675421, 104951191, 118302369,
        -211267924, 190945315, -99913085, 17090806, 32615602, -39127645, 26876462,
        -9767611, 2347385, 0, 0, 0, 0, 0},
      '{-267731977, 483089256, -657011032, 745720148, -672632742, 484816504, -204120898,
        -70063591, 295375657, -408003855, 418452168, -333118129, 211799264, -87930298,
        3175915, 42382789, -47882104, 35490814, -17496839, 6090817, 0},
      '{-163359928, 226154923, -240770292, 263417172, -214403629, 181532586, -108162248,
        70302653, -15991993, -4154952, 29416576, -25183168, 27766478, -15785404,
        10165894, -1683389, 0, 0, 0, 0, 0},
      '{-82901299, 98922658, -59825712, 100288093, -59938216, 79502451, -42723316,
        54492527, -30792606, 36871800, -18792048, 22611271, -10573342, 11435491,
        -3880068, 4084220, 0, 0, 0, 0, 0},
      '{-6522997, 54981261, 40278548, 31783769, 28201798, 16985194, 15433364, 12507141,
        8903945, 6441012, 4714600, 3280524, 2849519, 1169501, 1183184,
        0, 0, 0, 0, 0, 0},
      '{-239257741, 343502975, -318537092, 181172717, 20124771, -147599077, 172109044,
        -97746700, 13790138, 38185903, -27421242, -6658421, 35223302, -37672344,
        23964277, -6867483, 0, 0, 0, 0, 0},
      '{-208339167, 304184508, -320478988, 275719261, -149786305, 34275946, 71733749,
        -107370579, 102258158, -56649995, 20968692, 6537853, -10322438, 6744202,
        495197, 0, 0, 0, 0, 0, 0}
   };
   localparam int ROW_TAPS [NUM_ROWS] = '{1, 16, 20, 16, 16, 15, 16, 15};

   logic [2:0]  m_dither = 3'd0;
   logic [19:0] m_rate   = 20'd44100;
   logic [1:0]  m_width  = WIDTH_16;
   longint      err_hist [MAX_CHANNELS][HISTORY_DEPTH];

   pcm_word_type      pending [$];
   logic [CODE_W-1:0] code_q [$];
   int   errors  = 0;
   bit   no_idle = 1'b0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic longint q24(input longint m);
      return (m * 64'sd16777216 + ((m < 0) ? -64'sd50000000 : 64'sd50000000)) / 64'sd100000000;
   endfunction

   function automatic int shaping_row(input int sel, input logic [19:0] rate);
      int r;
      case (rate)
         RATE_48K:   r = 1;
         RATE_44K1:  r = 2;
         RATE_37K8:  r = 3;
         RATE_32K:   r = 4;
         RATE_22K05: r = 5;
         default:    r = 6;
      endcase
      if (sel == 1 || r == 6) r = 0;
      if (sel == 3 && (r == 1 || r == 2)) r += 5;
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] quantize(input pcm_word_type w);
      int     ch, bits, fb, setting, row, taps;
      longint smp, whole, frac, delta, acc, t, ti, tf, n, rnd, hi, lo;
      bit     inc;
      ch = int'(w.ch) % MAX_CHANNELS;
      smp = longint'(w.smp);
      bits = 8 * (int'(m_width) + 1);
      fb = 32 - bits;
      setting = (m_dither > 3'd4) ? 4 : int'(m_dither);
      whole = smp >>> fb;
      frac = (smp - (whole <<< fb)) <<< (24 - fb);
      delta = 0;
      taps = 0;
      if (setting != 0) begin
         row = shaping_row(setting - 1, m_rate);
         taps = ROW_TAPS[row];
         delta = longint'(w.nz);
         if (setting > 1) begin
            acc = 0;
            for (int k = 0; k < taps; k++) acc += q24(TAP_E8[row][k]) * err_hist[ch][k];
            delta += (acc + (64'sd1 <<< 23)) >>> 24;
         end
      end
      t = frac + delta;
      ti = t >>> 24;
      tf = t - (ti <<< 24);
      n = whole + ti;
      inc = (tf > (64'sd1 <<< 23)) || (tf == (64'sd1 <<< 23) && n[0]);
      rnd = n + (inc ? 1 : 0);
      if (setting != 0) begin
         for (int k = taps - 1; k > 0; k--) err_hist[ch][k] = err_hist[ch][k-1];
         err_hist[ch][0] = tf - (inc ? (64'sd1 <<< 24) : 0);
      end
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (rnd > hi) rnd = hi;
      if (rnd < lo) rnd = lo;
      if (bits == 8) rnd += 128;
      return CODE_W'(rnd) & CODE_W'((64'sd1 <<< bits) - 1);
   endfunction

   function automatic void clear_history();
      foreach (err_hist[c, k]) err_hist[c][k] = 0;
   endfunction

   // request driver: predicts on acceptance, then presents the next word
   always @(posedge clock) begin
      pcm_word_type w;
      logic         nxt_valid;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.channel <= '0;
         req_if.sample  <= '0;
         req_if.noise   <= '0;
      end else begin
         nxt_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            code_q.push_back(quantize({req_if.channel, req_if.sample, req_if.noise}));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid && pending.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
            w = pending.pop_front();
            req_if.channel <= w.ch;
            req_if.sample  <= w.smp;
            req_if.noise   <= w.nz;
            nxt_valid = 1'b1;
         end
         req_if.valid <= nxt_valid;
      end
   end

   // response monitor
   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (code_q.size() == 0) begin
            report($sformatf("unexpected code %h", rsp_if.sample_code));
         end else begin
            want = code_q.pop_front();
            if (rsp_if.sample_code !== want)
               report($sformatf("sample_code %h, want %h", rsp_if.sample_code, want));
         end
      end
      rsp_if.ready <= no_idle || $urandom_range(99) >= 26;
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_DITHER: begin m_dither = val[2:0]; clear_history(); end
         REG_RATE:   begin m_rate = val[19:0]; clear_history(); end
         REG_WIDTH:  m_width = val[1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending.size() != 0 || req_if.valid || code_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic pcm_word_type random_word();
      pcm_word_type w;
      logic [63:0]  r;
      r = {$urandom(), $urandom()};
      w.ch = CH_W'($urandom_range(7));
      case ($urandom_range(3))
         0: w.smp = r[39:0];
         1: w.smp = SAMPLE_W'($signed(r[31:0]));
         2: w.smp = SAMPLE_W'($signed(r[20:0]));
         default: w.smp = SAMPLE_W'($signed(r[35:0]));
      endcase
      if ($urandom_range(9) == 0) w.nz = NOISE_W'($urandom());
      else w.nz = NOISE_W'($signed($urandom_range(6039798)) - 3019899);
      return w;
   endfunction

   localparam logic [2:0]  PH_DITHER [NPHASE] = '{0, 1, 2, 3, 4, 5, 7, 3, 4, 3, 4, 2, 3, 4};
   localparam logic [19:0] PH_RATE [NPHASE] = '{44100, 48000, 44100, 37800, 32000, 22050,
      1234, 48000, 44100, 0, 768000, 20'hFFFFF, 22050, 37800};

   initial begin
      clear_history();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: extremes, half-LSB ties, channels
      pending.push_back('{3'd0, 40'sh7FFFFFFFFF, 23'sd0});
      pending.push_back('{3'd1, -40'sh8000000000, 23'sd0});
      pending.push_back('{3'd2, 40'sd0, 23'sd3019899});
      pending.push_back('{3'd3, 40'sh0000008000, -23'sd3019899});
      pending.push_back('{3'd4, 40'sh0000018000, 23'sh3FFFFF});
      pending.push_back('{3'd5, -40'sh0000008000, -23'sh400000});
      pending.push_back('{3'd6, 40'sh007FFF7FFF, 23'sd0});
      pending.push_back('{3'd7, 40'shFFFFFFFFFF, 23'sd0});
      wait_drained();

      for (int p = 0; p < NPHASE; p++) begin
         csr_write(REG_DITHER, 32'(PH_DITHER[p]));
         csr_write(REG_RATE, 32'(PH_RATE[p]));
         csr_write(REG_WIDTH, 32'(p % 4));
         no_idle = (p == 8);
         if (p == 3) begin
            // dither on: extremes
            pending.push_back('{3'd0, 40'sh7FFFFFFFFF, 23'sd3019899});
            pending.push_back('{3'd0, -40'sh8000000000, -23'sd3019899});
            pending.push_back('{3'd1, 40'sh0000800000, 23'sh3FFFFF});
            pending.push_back('{3'd1, 40'sd0, -23'sh400000});
         end
         for (int i = 0; i < 103; i++) pending.push_back(random_word());
         wait_drained();
      end

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/nsdq_pkg.sv
hw/rtl/nsdq_if.sv
hw/rtl/nsdq_ram.sv
hw/rtl/noise_shaped_dither_quantizer_top.sv
dv/testbench.sv
